// File: rtl/cpvp_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded position/velocity PID package
// Fixed-point formats, limits, register indexes and helper functions shared
// by the controller and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpvp_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int REPORT_INTERVAL = 10;
  localparam int GAIN_SHIFT      = 16;
  localparam int WEIGHT_SHIFT    = 16;
  localparam int DUTY_SHIFT      = GAIN_SHIFT + FRAC_BITS;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = MUL_P_W + 2;
  localparam int RND_W   = ACC_W - GAIN_SHIFT;

  localparam int GAIN_W   = 24;
  localparam int WEIGHT_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int DUTY_W   = 9;
  localparam int ATV_W    = 26;
  localparam int RPT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_VEL_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd6;

  localparam logic [GAIN_W-1:0]   RST_VEL_KP = 24'd655360;
  localparam logic [GAIN_W-1:0]   RST_VEL_KI = 24'd6554;
  localparam logic [GAIN_W-1:0]   RST_VEL_KD = 24'd0;
  localparam logic [GAIN_W-1:0]   RST_POS_KP = 24'd1310720;
  localparam logic [GAIN_W-1:0]   RST_POS_KI = 24'd6554;
  localparam logic [GAIN_W-1:0]   RST_POS_KD = 24'd655360;
  localparam logic [WEIGHT_W-1:0] RST_SMOOTH = 17'd3277;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam longint VEL_PER_COUNT_VAL = ((64'sd400000 <<< FRAC_BITS) + 64'sd968) / 64'sd1936;
  localparam longint POS_PER_COUNT_VAL = ((64'sd400 <<< FRAC_BITS) + 64'sd968) / 64'sd1936;
  localparam longint MIN_VEL_VAL       = ((64'sd49 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam longint MAX_VEL_VAL       = ((64'sd4001 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam longint MAX_POS_VAL       = ((64'sd2001 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam longint TRAVEL_VAL        = 64'sd200 <<< FRAC_BITS;
  localparam longint INTEG_VAL         = 64'sd1000 <<< FRAC_BITS;

  localparam logic signed [MUL_B_W-1:0] VEL_PER_COUNT = MUL_B_W'(VEL_PER_COUNT_VAL);
  localparam logic signed [MUL_B_W-1:0] POS_PER_COUNT = MUL_B_W'(POS_PER_COUNT_VAL);
  localparam logic signed [RND_W-1:0]   MIN_VEL_P     = RND_W'(MIN_VEL_VAL);
  localparam logic signed [RND_W-1:0]   MIN_VEL_N     = RND_W'(-MIN_VEL_VAL);
  localparam logic signed [RND_W-1:0]   MAX_VEL_P     = RND_W'(MAX_VEL_VAL);
  localparam logic signed [RND_W-1:0]   MAX_VEL_N     = RND_W'(-MAX_VEL_VAL);
  localparam logic signed [31:0]        MAX_POS_P     = 32'(MAX_POS_VAL);
  localparam logic signed [31:0]        MAX_POS_N     = 32'(-MAX_POS_VAL);
  localparam logic signed [31:0]        TRAVEL_Q      = 32'(TRAVEL_VAL);
  localparam logic signed [32:0]        INTEG_P       = 33'(INTEG_VAL);
  localparam logic signed [32:0]        INTEG_N       = 33'(-INTEG_VAL);
  localparam logic signed [ATV_W-1:0]   ATV_MAX       = ATV_W'(MAX_VEL_VAL);
  localparam logic signed [ATV_W-1:0]   ATV_MIN       = ATV_W'(-MAX_VEL_VAL);
  localparam logic [7:0]                DUTY_MAX      = 8'd255;
  localparam logic signed [ACC_W-1:0]   ROUND_HALF    = ACC_W'(64'sd1 <<< (GAIN_SHIFT - 1));

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] limit_vel(input logic signed [RND_W-1:0] v);
    logic signed [31:0] r;
    if (v > MIN_VEL_P) begin
      r = (v > MAX_VEL_P) ? MAX_VEL_P[31:0] : v[31:0];
    end else if (v < MIN_VEL_N) begin
      r = (v < MAX_VEL_N) ? MAX_VEL_N[31:0] : v[31:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] integ_clamp(input logic signed [31:0] acc,
                                                     input logic signed [31:0] err);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(acc) + 33'(err);
    if (s > INTEG_P) begin
      r = INTEG_P[31:0];
    end else if (s < INTEG_N) begin
      r = INTEG_N[31:0];
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cascaded_position_velocity_pid.sv
// ----------------------------------------------------------------------------
// Cascaded position/velocity PID controller
// One control tick per input transaction: encoder accumulation, velocity
// filter, optional outer position loop, inner velocity loop and limit rules.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_valid_i/in_stall_o carries one 1 ms tick
// (encoder delta, end-stop flag and an optional setpoint command). Exactly one
// result transaction on out_valid_o/out_stall_i follows for each tick, with the
// drive duty, filtered velocity, position, active velocity target and the
// report strobe.
// All arithmetic runs on a single shared 33x25 signed multiplier with a
// registered product and one accumulator, stepped by a small sequencer.
// A tick runs the velocity filter steps, then the position loop steps (in
// position mode only), then the velocity loop steps, DUTY and DONE;
// out_valid_o rises when DONE loads the result. The sequencer returns to idle
// before it accepts the next tick, and in_stall_o is high from acceptance until the sequencer is idle again.
// The result sits in an output register, so a stalled receiver only holds the
// sequencer in its final step; a new tick is still accepted while the previous
// result waits.
// The gain registers may be written only while the block is idle.
// Reset clears all loop state to zero, selects velocity mode and loads the
// default gains.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_position_velocity_pid (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [7:0]                       encoder_delta_i,
  input  logic                                    end_stop_i,
  input  logic                                    setpoint_valid_i,
  input  logic                                    mode_i,
  input  logic signed [31:0]                      setpoint_velocity_i,
  input  logic signed [31:0]                      setpoint_position_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [cpvp_pkg::DUTY_W-1:0]      duty_o,
  output logic signed [31:0]                      measured_velocity_o,
  output logic signed [31:0]                      measured_position_o,
  output logic signed [cpvp_pkg::ATV_W-1:0]       active_target_velocity_o,
  output logic                                    report_strobe_o,
  input  logic                                    cfg_we_i,
  input  logic [cpvp_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [cpvp_pkg::GAIN_W-1:0]             cfg_wdata_i
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_VPC  = 19'h00002,
    S_TW   = 19'h00004,
    S_VE   = 19'h00008,
    S_VSUM = 19'h00010,
    S_POS  = 19'h00020,
    S_PERR = 19'h00040,
    S_PINT = 19'h00080,
    S_PKI  = 19'h00100,
    S_PKD  = 19'h00200,
    S_PACC = 19'h00400,
    S_PLIM = 19'h00800,
    S_VERR = 19'h01000,
    S_VINT = 19'h02000,
    S_VKI  = 19'h04000,
    S_VKD  = 19'h08000,
    S_VACC = 19'h10000,
    S_DUTY = 19'h20000,
    S_DONE = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [cpvp_pkg::GAIN_W-1:0]   vkp_q, vki_q, vkd_q, pkp_q, pki_q, pkd_q;
  logic [cpvp_pkg::WEIGHT_W-1:0] sw_q;
  logic [cpvp_pkg::WEIGHT_W-1:0] w_eff, w_rest;

  logic [31:0]        count_q, count_d;
  logic signed [31:0] vest_q, vest_d;
  logic signed [31:0] pos_q, pos_d;
  logic signed [31:0] tv_q, tv_d;
  logic signed [31:0] tp_q, tp_d;
  logic               mode_q, mode_d;
  logic signed [31:0] pint_q, pint_d;
  logic signed [31:0] plast_q, plast_d;
  logic signed [31:0] vint_q, vint_d;
  logic signed [31:0] vlast_q, vlast_d;
  logic [cpvp_pkg::RPT_W-1:0] rc_q, rc_d;
  logic [cpvp_pkg::RPT_W-1:0] rc_inc;
  logic               strobe_q, strobe_d;
  logic               out_valid_q, out_valid_d;

  logic signed [7:0]  delta_q, delta_d;
  logic               stop_q, stop_d;
  logic               cmd_q, cmd_d;
  logic               cmode_q, cmode_d;
  logic signed [31:0] spv_q, spv_d;
  logic signed [31:0] spp_q, spp_d;

  logic signed [31:0]                     err_q, err_d;
  logic signed [32:0]                     diff_q, diff_d;
  logic signed [cpvp_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic signed [cpvp_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic signed [cpvp_pkg::MUL_P_W-1:0]    p_q, p_d;
  logic signed [cpvp_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [cpvp_pkg::MUL_B_W-1:0]    mul_b;

  logic signed [cpvp_pkg::ACC_W-1:0]      acc_rnd;
  logic signed [cpvp_pkg::RND_W-1:0]      acc_rnd_hi;
  logic [cpvp_pkg::ACC_W-1:0]             acc_mag;
  logic [cpvp_pkg::ACC_W-cpvp_pkg::DUTY_SHIFT-1:0] mag_hi;
  logic [7:0]                             mag8;

  logic signed [cpvp_pkg::DUTY_W-1:0]     out_duty_q;
  logic signed [31:0]                     out_vel_q, out_pos_q;
  logic signed [cpvp_pkg::ATV_W-1:0]      out_atv_q;
  logic                                   out_strobe_q;
  logic                                   out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vkp_q <= cpvp_pkg::RST_VEL_KP;
      vki_q <= cpvp_pkg::RST_VEL_KI;
      vkd_q <= cpvp_pkg::RST_VEL_KD;
      pkp_q <= cpvp_pkg::RST_POS_KP;
      pki_q <= cpvp_pkg::RST_POS_KI;
      pkd_q <= cpvp_pkg::RST_POS_KD;
      sw_q  <= cpvp_pkg::RST_SMOOTH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpvp_pkg::CFG_VEL_KP: vkp_q <= cfg_wdata_i;
        cpvp_pkg::CFG_VEL_KI: vki_q <= cfg_wdata_i;
        cpvp_pkg::CFG_VEL_KD: vkd_q <= cfg_wdata_i;
        cpvp_pkg::CFG_POS_KP: pkp_q <= cfg_wdata_i;
        cpvp_pkg::CFG_POS_KI: pki_q <= cfg_wdata_i;
        cpvp_pkg::CFG_POS_KD: pkd_q <= cfg_wdata_i;
        cpvp_pkg::CFG_SMOOTH: sw_q  <= cfg_wdata_i[cpvp_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff  = (sw_q > cpvp_pkg::WEIGHT_ONE) ? cpvp_pkg::WEIGHT_ONE : sw_q;
  assign w_rest = cpvp_pkg::WEIGHT_ONE - w_eff;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VPC: begin
        mul_a = cpvp_pkg::MUL_A_W'(delta_q);
        mul_b = cpvp_pkg::VEL_PER_COUNT;
      end
      S_TW: begin
        mul_a = p_q[cpvp_pkg::MUL_A_W-1:0];
        mul_b = cpvp_pkg::MUL_B_W'(w_eff);
      end
      S_VE: begin
        mul_a = cpvp_pkg::MUL_A_W'(vest_q);
        mul_b = cpvp_pkg::MUL_B_W'(w_rest);
      end
      S_VSUM: begin
        mul_a = cpvp_pkg::MUL_A_W'(signed'(count_q));
        mul_b = cpvp_pkg::POS_PER_COUNT;
      end
      S_PINT: begin
        mul_a = cpvp_pkg::MUL_A_W'(err_q);
        mul_b = cpvp_pkg::MUL_B_W'(pkp_q);
      end
      S_PKI: begin
        mul_a = cpvp_pkg::MUL_A_W'(pint_q);
        mul_b = cpvp_pkg::MUL_B_W'(pki_q);
      end
      S_PKD: begin
        mul_a = diff_q;
        mul_b = cpvp_pkg::MUL_B_W'(pkd_q);
      end
      S_VINT: begin
        mul_a = cpvp_pkg::MUL_A_W'(err_q);
        mul_b = cpvp_pkg::MUL_B_W'(vkp_q);
      end
      S_VKI: begin
        mul_a = cpvp_pkg::MUL_A_W'(vint_q);
        mul_b = cpvp_pkg::MUL_B_W'(vki_q);
      end
      S_VKD: begin
        mul_a = diff_q;
        mul_b = cpvp_pkg::MUL_B_W'(vkd_q);
      end
      default: ;
    endcase
  end

  assign p_d        = mul_a * mul_b;
  assign acc_rnd    = acc_q + cpvp_pkg::ROUND_HALF;
  assign acc_rnd_hi = acc_rnd[cpvp_pkg::ACC_W-1:cpvp_pkg::GAIN_SHIFT];
  assign acc_mag    = acc_q[cpvp_pkg::ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
  assign mag_hi     = acc_mag[cpvp_pkg::ACC_W-1:cpvp_pkg::DUTY_SHIFT];
  assign mag8       = (mag_hi > cpvp_pkg::DUTY_MAX) ? cpvp_pkg::DUTY_MAX : mag_hi[7:0];
  assign rc_inc     = rc_q + cpvp_pkg::RPT_W'(1);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    vest_d      = vest_q;
    pos_d       = pos_q;
    tv_d        = tv_q;
    tp_d        = tp_q;
    mode_d      = mode_q;
    pint_d      = pint_q;
    plast_d     = plast_q;
    vint_d      = vint_q;
    vlast_d     = vlast_q;
    rc_d        = rc_q;
    strobe_d    = strobe_q;
    delta_d     = delta_q;
    stop_d      = stop_q;
    cmd_d       = cmd_q;
    cmode_d     = cmode_q;
    spv_d       = spv_q;
    spp_d       = spp_q;
    err_d       = err_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    duty_d      = duty_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          delta_d = encoder_delta_i;
          stop_d  = end_stop_i;
          cmd_d   = setpoint_valid_i;
          cmode_d = mode_i;
          spv_d   = setpoint_velocity_i;
          spp_d   = setpoint_position_i;
          count_d = count_q + unsigned'(32'(encoder_delta_i));
          state_d = S_VPC;
        end
      end
      S_VPC: state_d = S_TW;
      S_TW:  state_d = S_VE;
      S_VE: begin
        acc_d   = cpvp_pkg::ACC_W'(p_q);
        state_d = S_VSUM;
      end
      S_VSUM: begin
        acc_d   = acc_q + cpvp_pkg::ACC_W'(p_q);
        state_d = S_POS;
      end
      S_POS: begin
        vest_d  = cpvp_pkg::sat32(cpvp_pkg::ACC_W'(acc_rnd_hi));
        pos_d   = cpvp_pkg::sat32(cpvp_pkg::ACC_W'(p_q));
        state_d = mode_q ? S_PERR : S_VERR;
      end
      S_PERR: begin
        err_d   = cpvp_pkg::sat32(cpvp_pkg::ACC_W'(tp_q) - cpvp_pkg::ACC_W'(pos_q));
        state_d = S_PINT;
      end
      S_PINT: begin
        pint_d  = cpvp_pkg::integ_clamp(pint_q, err_q);
        diff_d  = 33'(err_q) - 33'(plast_q);
        state_d = S_PKI;
      end
      S_PKI: begin
        acc_d   = cpvp_pkg::ACC_W'(p_q);
        state_d = S_PKD;
      end
      S_PKD: begin
        acc_d   = acc_q + cpvp_pkg::ACC_W'(p_q);
        state_d = S_PACC;
      end
      S_PACC: begin
        acc_d   = acc_q + cpvp_pkg::ACC_W'(p_q);
        state_d = S_PLIM;
      end
      S_PLIM: begin
        tv_d    = cpvp_pkg::limit_vel(acc_rnd_hi);
        plast_d = err_q;
        state_d = S_VERR;
      end
      S_VERR: begin
        err_d   = cpvp_pkg::sat32(cpvp_pkg::ACC_W'(tv_q) - cpvp_pkg::ACC_W'(vest_q));
        state_d = S_VINT;
      end
      S_VINT: begin
        vint_d  = cpvp_pkg::integ_clamp(vint_q, err_q);
        diff_d  = 33'(err_q) - 33'(vlast_q);
        state_d = S_VKI;
      end
      S_VKI: begin
        acc_d   = cpvp_pkg::ACC_W'(p_q);
        state_d = S_VKD;
      end
      S_VKD: begin
        acc_d   = acc_q + cpvp_pkg::ACC_W'(p_q);
        state_d = S_VACC;
      end
      S_VACC: begin
        acc_d   = acc_q + cpvp_pkg::ACC_W'(p_q);
        state_d = S_DUTY;
      end
      S_DUTY: begin
        vlast_d = err_q;
        duty_d  = acc_q[cpvp_pkg::ACC_W-1] ? -cpvp_pkg::DUTY_W'(mag8)
                                          : cpvp_pkg::DUTY_W'(mag8);
        if (stop_q && tv_q[31]) begin
          tv_d    = '0;
          count_d = '0;
        end else if (pos_q > cpvp_pkg::TRAVEL_Q && !tv_q[31] && tv_q != '0) begin
          tv_d = '0;
        end
        if (cmd_q) begin
          mode_d = cmode_q;
          if (!cmode_q) begin
            tv_d = cpvp_pkg::limit_vel(cpvp_pkg::RND_W'(spv_q));
          end else if (spp_q > cpvp_pkg::MAX_POS_P) begin
            tp_d = cpvp_pkg::MAX_POS_P;
          end else if (spp_q < cpvp_pkg::MAX_POS_N) begin
            tp_d = cpvp_pkg::MAX_POS_N;
          end else begin
            tp_d = spp_q;
          end
        end
        if (rc_inc >= cpvp_pkg::RPT_W'(cpvp_pkg::REPORT_INTERVAL)) begin
          rc_d     = '0;
          strobe_d = 1'b1;
        end else begin
          rc_d     = rc_inc;
          strobe_d = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      vest_q      <= '0;
      pos_q       <= '0;
      tv_q        <= '0;
      tp_q        <= '0;
      mode_q      <= 1'b0;
      pint_q      <= '0;
      plast_q     <= '0;
      vint_q      <= '0;
      vlast_q     <= '0;
      rc_q        <= '0;
      strobe_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vest_q      <= vest_d;
      pos_q       <= pos_d;
      tv_q        <= tv_d;
      tp_q        <= tp_d;
      mode_q      <= mode_d;
      pint_q      <= pint_d;
      plast_q     <= plast_d;
      vint_q      <= vint_d;
      vlast_q     <= vlast_d;
      rc_q        <= rc_d;
      strobe_q    <= strobe_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    stop_q  <= stop_d;
    cmd_q   <= cmd_d;
    cmode_q <= cmode_d;
    spv_q   <= spv_d;
    spp_q   <= spp_d;
    err_q   <= err_d;
    diff_q  <= diff_d;
    acc_q   <= acc_d;
    duty_q  <= duty_d;
    p_q     <= p_d;
    if (out_load) begin
      out_duty_q   <= duty_q;
      out_vel_q    <= vest_q;
      out_pos_q    <= pos_q;
      out_atv_q    <= tv_q[cpvp_pkg::ATV_W-1:0];
      out_strobe_q <= strobe_q;
    end
  end

  assign in_stall_o               = (state_q != S_IDLE);
  assign out_valid_o              = out_valid_q;
  assign duty_o                   = out_duty_q;
  assign measured_velocity_o      = out_vel_q;
  assign measured_position_o      = out_pos_q;
  assign active_target_velocity_o = out_atv_q;
  assign report_strobe_o          = out_strobe_q;

endmodule

`default_nettype wire

// File: rtl/cpvp_checker.sv
// ----------------------------------------------------------------------------
// Cascaded position/velocity PID port checker
// Assertions on the controller's handshakes and result ranges, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpvp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [cpvp_pkg::DUTY_W-1:0]  duty_o,
  input logic signed [cpvp_pkg::ATV_W-1:0]   active_target_velocity_o
);

  // A result transaction is never withdrawn while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // After an input transaction the block is busy computing the tick.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice without computation");

  // A new result only appears at the end of a computation.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a computed tick");

  // Duty and active target stay within their limits.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_o != 9'sh100)
                    && (active_target_velocity_o <= cpvp_pkg::ATV_MAX)
                    && (active_target_velocity_o >= cpvp_pkg::ATV_MIN))
    else $error("result field out of range");

endmodule

bind cascaded_position_velocity_pid cpvp_checker u_cpvp_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .in_valid_i               (in_valid_i),
  .in_stall_o               (in_stall_o),
  .out_valid_o              (out_valid_o),
  .out_stall_i              (out_stall_i),
  .duty_o                   (duty_o),
  .active_target_velocity_o (active_target_velocity_o)
);

`default_nettype wire
